[hdl/uhs_pkg.sv]
package uhs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int HANDLE_W     = 64;
	localparam int OP_W         = 2;
	localparam int SLOT_W       = 6;
	localparam int STATUS_W     = 3;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_GET    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NULL      = 3'd4;

	localparam logic [1:0] RD_SLOT  = 2'd0;
	localparam logic [1:0] RD_FIRST = 2'd1;
	localparam logic [1:0] RD_NEXT  = 2'd2;
	localparam logic [1:0] RD_LAST  = 2'd3;

	localparam logic WR_ADD  = 1'b0;
	localparam logic WR_MOVE = 1'b1;

	typedef struct packed {
		logic                capture;
		logic                rd_en;
		logic [1:0]          rd_sel;
		logic                wr_en;
		logic                wr_sel;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                idx_clr;
		logic                idx_inc;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_use_data;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic            in_null;
		logic            full;
		logic            slot_ok;
		logic            cnt_zero;
		logic            match;
		logic            scan_more;
		logic            out_free;
	} sts_t;

endpackage

[hdl/unordered_handle_set_top.sv]
// add and failed ops load their result as the input beat is taken; get reads the slot, then loads the data read;
// remove scans from index 0 until the match (not found when absent), then moves the last entry into its place
// one item in flight; remove scans one entry per cycle through the single ram read port
// the next input beat is taken while a finished result waits in the output register
// arst_n clears the count and control state; table contents are undefined until written
module unordered_handle_set_top #(
	parameter int CAPACITY = uhs_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [uhs_pkg::OP_W-1:0]      op,
	input  logic [uhs_pkg::HANDLE_W-1:0]  handle,
	input  logic [uhs_pkg::SLOT_W-1:0]    slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [uhs_pkg::STATUS_W-1:0]  status,
	output logic [uhs_pkg::HANDLE_W-1:0]  handle_out,
	output logic [$clog2(CAPACITY+1)-1:0] occupancy
);

	import uhs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	uhs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	uhs_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.handle    (handle),
		.slot      (slot),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.handle_out(handle_out),
		.occupancy (occupancy)
	);

endmodule

[hdl/uhs_ram.sv]
module uhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/uhs_ctrl.sv]
module uhs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  uhs_pkg::sts_t sts,
	output uhs_pkg::cmd_t cmd
);

	import uhs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_GET  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (sts.in_op)
						OP_ADD: begin
							cmd.res_load = 1'b1;
							state_d      = S_DONE;
							if (sts.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.wr_en      = 1'b1;
								cmd.wr_sel     = WR_ADD;
								cmd.cnt_inc    = 1'b1;
								cmd.res_status = ST_OK;
							end
						end
						OP_REMOVE: begin
							if (sts.in_null) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_NULL;
								state_d        = S_DONE;
							end else if (sts.cnt_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_NOT_FOUND;
								state_d        = S_DONE;
							end else begin
								cmd.rd_en   = 1'b1;
								cmd.rd_sel  = RD_FIRST;
								cmd.idx_clr = 1'b1;
								state_d     = S_SCAN;
							end
						end
						OP_GET: begin
							if (sts.slot_ok) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_SLOT;
								state_d    = S_GET;
							end else begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_RANGE;
								state_d        = S_DONE;
							end
						end
						default: begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LAST;
					state_d    = S_MOVE;
				end else if (sts.scan_more) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_DONE;
				end
			end
			S_MOVE: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_MOVE;
				cmd.cnt_dec    = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_DONE;
			end
			S_GET: begin
				cmd.res_load     = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_use_data = 1'b1;
				state_d          = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/uhs_dp.sv]
module uhs_dp #(
	parameter int CAPACITY = uhs_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uhs_pkg::cmd_t                 cmd,
	output uhs_pkg::sts_t                 sts,
	input  logic [uhs_pkg::OP_W-1:0]      op,
	input  logic [uhs_pkg::HANDLE_W-1:0]  handle,
	input  logic [uhs_pkg::SLOT_W-1:0]    slot,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [uhs_pkg::STATUS_W-1:0]  status,
	output logic [uhs_pkg::HANDLE_W-1:0]  handle_out,
	output logic [$clog2(CAPACITY+1)-1:0] occupancy
);

	import uhs_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [CNT_W-1:0]    out_occ_q;

	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;
	logic [HANDLE_W-1:0] wr_data;
	logic [HANDLE_W-1:0] rd_data;
	logic [ADDR_W-1:0]   last_addr;
	logic [CNT_W-1:0]    idx_next;

	assign last_addr = ADDR_W'(count_q - CNT_W'(1));
	assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_SLOT:  rd_addr = ADDR_W'(slot);
			RD_FIRST: rd_addr = '0;
			RD_NEXT:  rd_addr = ADDR_W'(idx_next);
			RD_LAST:  rd_addr = last_addr;
			default:  rd_addr = '0;
		endcase
	end

	assign wr_addr = (cmd.wr_sel == WR_MOVE) ? idx_q : ADDR_W'(count_q);
	assign wr_data = (cmd.wr_sel == WR_MOVE) ? rd_data : handle;

	uhs_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			handle_q <= handle;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= ADDR_W'(idx_next);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_handle_q <= cmd.res_use_data ? rd_data : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_occ_q    <= count_q;
		end
	end

	assign sts.in_op     = op;
	assign sts.in_null   = (handle == '0);
	assign sts.full      = (count_q == CNT_W'(CAPACITY));
	assign sts.slot_ok   = (CMP_W'(slot) < CMP_W'(count_q));
	assign sts.cnt_zero  = (count_q == '0);
	assign sts.match     = (rd_data == handle_q);
	assign sts.scan_more = (idx_next < count_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign handle_out = out_handle_q;
	assign occupancy  = out_occ_q;

endmodule

[tb/sv/tb_unordered_handle_set_top.sv]
`timescale 1ns / 100ps

module tb_unordered_handle_set_top;
	import uhs_pkg::*;

	localparam int SET_CAP = CAPACITY_DEF;
	localparam int OCC_W = $clog2(SET_CAP + 1);
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	localparam logic [HANDLE_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] value;
		logic [OCC_W-1:0]    occ;
	} outcome_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [HANDLE_W-1:0] handle;
	logic [SLOT_W-1:0]   slot;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [OCC_W-1:0]    occupancy;

	logic [HANDLE_W-1:0] shadow_tbl [SET_CAP];
	int                  shadow_cnt;
	outcome_t            awaited_outcomes [$];
	int                  bad_results;
	int                  tx_idle_pct;
	int                  rx_idle_pct;

	unordered_handle_set_top #(.CAPACITY(SET_CAP)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.handle     (handle),
		.slot       (slot),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.handle_out (handle_out),
		.occupancy  (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("unordered_handle_set_top: mismatch");
		$finish;
	end

	function automatic outcome_t apply_set_op(input logic [OP_W-1:0] op_v,
			input logic [HANDLE_W-1:0] h, input logic [SLOT_W-1:0] s);
		outcome_t r;
		bit hit;
		int at;
		r.status = ST_OK;
		r.value = '0;
		hit = 1'b0;
		at = 0;
		case (op_v)
			OP_ADD: begin
				if (shadow_cnt >= SET_CAP) begin
					r.status = ST_FULL;
				end else begin
					shadow_tbl[shadow_cnt] = h;
					shadow_cnt++;
				end
			end
			OP_REMOVE: begin
				if (h == '0) begin
					r.status = ST_NULL;
				end else begin
					for (int i = 0; i < shadow_cnt && !hit; i++) begin
						if (shadow_tbl[i] == h) begin
							hit = 1'b1;
							at = i;
						end
					end
					if (!hit) begin
						r.status = ST_NOT_FOUND;
					end else begin
						shadow_tbl[at] = shadow_tbl[shadow_cnt-1];
						shadow_cnt--;
					end
				end
			end
			OP_GET: begin
				if (int'(s) >= shadow_cnt) begin
					r.status = ST_RANGE;
				end else begin
					r.value = shadow_tbl[s];
				end
			end
			default: begin
			end
		endcase
		r.occ = OCC_W'(shadow_cnt);
		return r;
	endfunction

	// small pool values make duplicates likely
	function automatic logic [HANDLE_W-1:0] rand_handle();
		if ($urandom_range(2) == 0)
			return {56'h0, 8'($urandom_range(1, 255))};
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(input logic [OP_W-1:0] op_v, input logic [HANDLE_W-1:0] h,
			input logic [SLOT_W-1:0] s);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_v;
		handle <= h;
		slot <= s;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		awaited_outcomes.push_back(apply_set_op(op_v, h, s));
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(negedge clk) begin : check_result
		outcome_t want;
		outcome_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, handle_out, occupancy};
			if (awaited_outcomes.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result beat with nothing pending: status %0d handle_out %h occupancy %0d",
						$realtime, status, handle_out, occupancy);
			end else begin
				want = awaited_outcomes.pop_front();
				if (got !== want) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%0t: bad result: status %0d/%0d handle_out %h/%h occupancy %0d/%0d (got/want)",
							$realtime, got.status, want.status, got.value, want.value,
							got.occ, want.occ);
				end
			end
		end
	end

	task automatic test_directed_corners();
		send_beat(OP_GET, '0, 6'd0);
		send_beat(OP_GET, ALL_ONES, 6'd63);
		send_beat(OP_REMOVE, '0, 6'd0);
		send_beat(OP_REMOVE, ALL_ONES, 6'd63);
		send_beat(OP_IGNORED, ALL_ONES, 6'd63);
		send_beat(OP_ADD, '0, 6'd0);
		send_beat(OP_ADD, ALL_ONES, 6'd63);
		send_beat(OP_ADD, 64'h8000_0000_0000_0001, 6'd21);
		send_beat(OP_ADD, ALL_ONES, 6'd42);
		send_beat(OP_GET, '0, 6'd0);
		send_beat(OP_GET, '0, 6'd3);
		send_beat(OP_GET, '0, 6'd4);
		send_beat(OP_GET, '0, 6'd63);
		// duplicate: lowest copy goes, last entry moves in
		send_beat(OP_REMOVE, ALL_ONES, 6'd0);
		send_beat(OP_GET, '0, 6'd1);
		send_beat(OP_REMOVE, '0, 6'd1);
		send_beat(OP_REMOVE, 64'h0000_0000_0000_1234, 6'd2);
		send_beat(OP_REMOVE, 64'h8000_0000_0000_0001, 6'd0);
		send_beat(OP_REMOVE, ALL_ONES, 6'd0);
		send_beat(OP_REMOVE, ALL_ONES, 6'd0);
		send_beat(OP_GET, ALL_ONES, 6'd0);
		send_beat(OP_IGNORED, '0, 6'd0);
		send_beat(OP_GET, '0, 6'd1);
	endtask

	task automatic test_fill_and_drain();
		int guard;
		logic [HANDLE_W-1:0] h;
		while (shadow_cnt < SET_CAP)
			send_beat(OP_ADD, rand_handle(), 6'($urandom));
		send_beat(OP_ADD, ALL_ONES, '0);
		send_beat(OP_ADD, '0, 6'd63);
		send_beat(OP_GET, '0, 6'd63);
		repeat (6) send_beat(OP_GET, rand_handle(), 6'($urandom));
		send_beat(OP_IGNORED, {$urandom, $urandom}, 6'($urandom));
		guard = 0;
		while (shadow_cnt > 1 && guard < 200) begin
			guard++;
			h = shadow_tbl[$urandom_range(shadow_cnt - 1)];
			if ($urandom_range(9) == 0)
				send_beat(OP_REMOVE, {$urandom, $urandom}, 6'($urandom));
			else if (h == '0 || $urandom_range(9) == 0)
				send_beat(OP_GET, rand_handle(), 6'($urandom_range(shadow_cnt - 1)));
			else
				send_beat(OP_REMOVE, h, 6'($urandom));
		end
	endtask

	task automatic test_random_mix(input int n);
		int done;
		int pick;
		logic [HANDLE_W-1:0] h;
		logic [SLOT_W-1:0] s;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			s = 6'($urandom);
			if (pick < 5) begin
				send_beat(OP_IGNORED, {$urandom, $urandom}, s);
			end else begin
				done++;
				if (pick < 40) begin
					send_beat(OP_ADD, rand_handle(), s);
				end else if (pick < 75) begin
					if (shadow_cnt > 0 && $urandom_range(9) < 7)
						h = shadow_tbl[$urandom_range(shadow_cnt - 1)];
					else if ($urandom_range(3) == 0)
						h = '0;
					else
						h = rand_handle();
					send_beat(OP_REMOVE, h, s);
				end else begin
					if (shadow_cnt > 0 && $urandom_range(9) < 8)
						s = 6'($urandom_range(shadow_cnt - 1));
					send_beat(OP_GET, rand_handle(), s);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		handle = '0;
		slot = '0;
		shadow_cnt = 0;
		bad_results = 0;
		tx_idle_pct = 29;
		rx_idle_pct = 66;
		for (int i = 0; i < SET_CAP; i++)
			shadow_tbl[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_fill_and_drain();
		test_random_mix(150);

		tx_idle_pct = 66;
		rx_idle_pct = 29;
		test_fill_and_drain();
		test_random_mix(150);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_fill_and_drain();
		test_random_mix(150);

		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (bad_results == 0)
			$display("unordered_handle_set_top: match");
		else
			$display("unordered_handle_set_top: mismatch");
		$finish;
	end

endmodule
